// ===== design/sfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial NOR flash read responder.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int MEM_BYTES_DEF = 65536;

  localparam logic [1:0] MODE_SPI   = 2'd0;
  localparam logic [1:0] MODE_SEL   = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;
  localparam logic [1:0] MODE_LOAD  = 2'd3;

  localparam logic [7:0] OP_RDID  = 8'h9F;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_FAST  = 8'h0B;
  localparam logic [7:0] OP_QOUT  = 8'h6B;
  localparam logic [7:0] OP_QIO   = 8'hEB;

  localparam logic [7:0] ID_MFR   = 8'hEF;
  localparam logic [7:0] ID_TYPE  = 8'h40;
  localparam logic [7:0] ID_CAP   = 8'h18;
  localparam logic [7:0] ERASED   = 8'hFF;

  localparam logic [2:0] POS_ADDR0 = 3'd1;
  localparam logic [2:0] POS_ADDR1 = 3'd2;
  localparam logic [2:0] POS_ADDR2 = 3'd3;
  localparam logic [2:0] POS_DUMMY = 3'd4;
  localparam logic [2:0] POS_MAX   = 3'd5;

  localparam logic [1:0] ADDR_LAST = 2'd3;

  // response of one word, before the memory data is merged in
  typedef struct packed {
    logic       use_mem;
    logic       hit;
    logic [7:0] data;
    logic       rej;
  } sfr_resp_t;

endpackage
`default_nettype wire

// ===== design/sfr_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_mem
// Byte memory, one write and one registered read port, erased to 0xFF by a
// sweep of one byte per cycle after reset.
// ----------------------------------------------------------------------------
module sfr_mem #(
  parameter int MEM_BYTES = sfr_pkg::MEM_BYTES_DEF,
  parameter int AW        = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data,
  output logic               busy
);

  logic [7:0]    mem_r [MEM_BYTES];
  logic [7:0]    rd_data_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(MEM_BYTES - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem_r[clr_addr_r] <= sfr_pkg::ERASED;
    end else if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule
`default_nettype wire

// ===== design/sfr_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_decode
// Command state of the SPI and frame faces; issues memory reads and loads.
// ----------------------------------------------------------------------------
module sfr_decode #(
  parameter int MEM_BYTES = sfr_pkg::MEM_BYTES_DEF,
  parameter int AW        = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [1:0]       mode,
  input  wire logic [7:0]       data_in,
  input  wire logic             sel,
  input  wire logic             frame_start,
  input  wire logic [23:0]      load_addr,
  output logic                  mem_rd_en,
  output logic      [AW-1:0]    mem_rd_addr,
  output logic                  mem_wr_en,
  output logic      [AW-1:0]    mem_wr_addr,
  output logic      [7:0]       mem_wr_data,
  output sfr_pkg::sfr_resp_t    resp
);

  typedef enum logic [1:0] {PH_IDLE, PH_ADDR, PH_DATA, PH_IGNORE} phase_t;

  logic        sel_r,    sel_nxt;
  phase_t      phase_r,  phase_nxt;
  logic [31:0] sptr_r,   sptr_nxt;
  logic [1:0]  cnt_r,    cnt_nxt;
  logic [7:0]  opc_r,    opc_nxt;
  logic [2:0]  pos_r,    pos_nxt;
  logic [31:0] fptr_r,   fptr_nxt;

  logic [2:0]  pos_p;
  logic        rd_req;
  logic        wr_req;
  logic [31:0] rd_ptr;
  logic        load_hit;
  sfr_pkg::sfr_resp_t resp_c;

  assign pos_p    = (pos_r < sfr_pkg::POS_MAX) ? pos_r + 3'd1 : sfr_pkg::POS_MAX;
  assign load_hit = {1'b0, load_addr} < 25'(MEM_BYTES);

  always_comb begin
    sel_nxt   = sel_r;
    phase_nxt = phase_r;
    sptr_nxt  = sptr_r;
    cnt_nxt   = cnt_r;
    opc_nxt   = opc_r;
    pos_nxt   = pos_r;
    fptr_nxt  = fptr_r;
    rd_req    = 1'b0;
    wr_req    = 1'b0;
    rd_ptr    = '0;
    resp_c    = '0;
    case (mode)
      sfr_pkg::MODE_SPI: begin
        if (!sel_r) begin
          resp_c.data = data_in;
        end else begin
          case (phase_r)
            PH_IDLE: begin
              resp_c.data = sfr_pkg::ERASED;
              if (data_in == sfr_pkg::OP_READ) begin
                phase_nxt = PH_ADDR;
                sptr_nxt  = '0;
                cnt_nxt   = '0;
              end else begin
                phase_nxt = PH_IGNORE;
              end
            end
            PH_ADDR: begin
              resp_c.data = sfr_pkg::ERASED;
              sptr_nxt    = {sptr_r[23:0], data_in};
              cnt_nxt     = cnt_r + 2'd1;
              if (cnt_nxt == sfr_pkg::ADDR_LAST) begin
                phase_nxt = PH_DATA;
              end
            end
            PH_DATA: begin
              resp_c.use_mem = 1'b1;
              rd_req         = 1'b1;
              rd_ptr         = sptr_r;
              sptr_nxt       = sptr_r + 32'd1;
            end
            default: begin
              resp_c.data = sfr_pkg::ERASED;
            end
          endcase
        end
      end
      sfr_pkg::MODE_SEL: begin
        sel_nxt = sel;
        if (!sel) begin
          phase_nxt = PH_IDLE;
          sptr_nxt  = '0;
          cnt_nxt   = '0;
        end
      end
      sfr_pkg::MODE_FRAME: begin
        if (frame_start) begin
          opc_nxt = data_in;
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_p;
          if (pos_p inside {[sfr_pkg::POS_ADDR0:sfr_pkg::POS_ADDR2]}) begin
            fptr_nxt = (pos_p == sfr_pkg::POS_ADDR0) ? {24'd0, data_in}
                                                     : {fptr_r[23:0], data_in};
            if (opc_r == sfr_pkg::OP_RDID) begin
              case (pos_p)
                sfr_pkg::POS_ADDR0: resp_c.data = sfr_pkg::ID_MFR;
                sfr_pkg::POS_ADDR1: resp_c.data = sfr_pkg::ID_TYPE;
                default:            resp_c.data = sfr_pkg::ID_CAP;
              endcase
            end
          end else if (opc_r == sfr_pkg::OP_READ) begin
            resp_c.use_mem = 1'b1;
            rd_req         = 1'b1;
            rd_ptr         = fptr_r;
            fptr_nxt       = fptr_r + 32'd1;
          end else if (opc_r inside {sfr_pkg::OP_FAST, sfr_pkg::OP_QOUT,
                                     sfr_pkg::OP_QIO}) begin
            if (pos_p != sfr_pkg::POS_DUMMY) begin
              resp_c.use_mem = 1'b1;
              rd_req         = 1'b1;
              rd_ptr         = fptr_r;
              fptr_nxt       = fptr_r + 32'd1;
            end
          end
        end
      end
      default: begin
        if (load_hit) begin
          wr_req = 1'b1;
        end else begin
          resp_c.rej = 1'b1;
        end
      end
    endcase
    resp_c.hit = {1'b0, rd_ptr} < 33'(MEM_BYTES);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 1'b0;
      phase_r <= PH_IDLE;
      sptr_r  <= '0;
      cnt_r   <= '0;
      opc_r   <= '0;
      pos_r   <= '0;
      fptr_r  <= '0;
    end else if (accept) begin
      sel_r   <= sel_nxt;
      phase_r <= phase_nxt;
      sptr_r  <= sptr_nxt;
      cnt_r   <= cnt_nxt;
      opc_r   <= opc_nxt;
      pos_r   <= pos_nxt;
      fptr_r  <= fptr_nxt;
    end
  end

  assign mem_rd_en   = accept && rd_req && resp_c.hit;
  assign mem_rd_addr = rd_ptr[AW-1:0];
  assign mem_wr_en   = accept && wr_req;
  assign mem_wr_addr = load_addr[AW-1:0];
  assign mem_wr_data = data_in;
  assign resp        = resp_c;

endmodule
`default_nettype wire

// ===== design/spi_nor_flash_read_responder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spi_nor_flash_read_responder
// Read-only NOR flash responder with an SPI face and a frame face.
//
// Input words carry a mode (SPI byte, chip select change, frame byte, load
// byte) with their operands; every input word yields exactly one output word
// holding the response byte and a load reject flag.
// Path: an accepted word passes the memory read stage and then the output
// register before it appears on out_*.
// Throughput: one word per cycle while in_stall and out_stall are low; the
// byte memory takes at most one read or one write per accepted word.
// Reset: control state clears, then the memory is erased to 0xFF by a sweep
// over all MEM_BYTES bytes (65536 by default) during which in_stall is high.
// Stall: when out_stall is held, the output register and the read stage
// fill; after that in_stall rises until the receiver takes a word. Nothing
// is dropped or repeated.
// ----------------------------------------------------------------------------
module spi_nor_flash_read_responder #(
  parameter int MEM_BYTES = sfr_pkg::MEM_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_data_in,
  input  wire logic        in_select,
  input  wire logic        in_frame_start,
  input  wire logic [23:0] in_load_addr,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  out_data_out,
  output logic             out_load_rejected
);

  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

  logic          accept;
  logic          s1_adv;
  logic          busy;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    rd_data;
  logic [7:0]    s1_byte;
  sfr_pkg::sfr_resp_t resp;

  logic               s1_v_r;
  sfr_pkg::sfr_resp_t s1_resp_r;
  logic               out_v_r;
  logic [7:0]         out_data_r;
  logic               out_rej_r;

  assign s1_adv   = !out_v_r || !out_stall;
  assign in_stall = busy || (s1_v_r && !s1_adv);
  assign accept   = in_valid && !in_stall;

  sfr_decode #(
    .MEM_BYTES (MEM_BYTES),
    .AW        (AW)
  ) u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .mode        (in_mode),
    .data_in     (in_data_in),
    .sel         (in_select),
    .frame_start (in_frame_start),
    .load_addr   (in_load_addr),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_data (wr_data),
    .resp        (resp)
  );

  sfr_mem #(
    .MEM_BYTES (MEM_BYTES),
    .AW        (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (busy)
  );

  assign s1_byte = !s1_resp_r.use_mem ? s1_resp_r.data
                 : (s1_resp_r.hit ? rd_data : sfr_pkg::ERASED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_v_r && s1_adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_resp_r <= resp;
    end
    if (s1_v_r && s1_adv) begin
      out_data_r <= s1_byte;
      out_rej_r  <= s1_resp_r.rej;
    end
  end

  assign out_valid         = out_v_r;
  assign out_data_out      = out_data_r;
  assign out_load_rejected = out_rej_r;

endmodule
`default_nettype wire

// ===== bench/sfr_read_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_read_checker
// Watches both channels of the flash read responder, keeps its own copy of
// the byte memory, the SPI command state and the frame decode state, works
// out the response word for every accepted input word and compares it, in
// order and field by field, with every accepted output word.
// ----------------------------------------------------------------------------
module sfr_read_checker #(
  parameter int MEM_BYTES = sfr_pkg::MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_data_in,
  input  logic        in_select,
  input  logic        in_frame_start,
  input  logic [23:0] in_load_addr,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_data_out,
  input  logic        out_load_rejected,
  output int          words_owed,
  output int          mismatch_count
);

  typedef enum logic [1:0] {SPI_IDLE, SPI_ADDR, SPI_DATA, SPI_IGNORE} spi_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       rej;
  } flash_resp_t;

  logic [7:0]  flash_mem [MEM_BYTES];
  logic        spi_sel;
  spi_phase_t  spi_phase;
  logic [31:0] spi_ptr;
  logic [1:0]  spi_cnt;
  logic [7:0]  frm_op;
  logic [2:0]  frm_pos;
  logic [31:0] frm_ptr;

  flash_resp_t owed_resp_q [$];

  initial begin
    words_owed     = 0;
    mismatch_count = 0;
  end

  function automatic logic [7:0] mem_byte(input logic [31:0] addr);
    if (addr >= MEM_BYTES) return sfr_pkg::ERASED;
    return flash_mem[addr];
  endfunction

  function automatic flash_resp_t flash_response(input logic [1:0]  mode,
                                                 input logic [7:0]  b,
                                                 input logic        sel,
                                                 input logic        fs,
                                                 input logic [23:0] la);
    flash_resp_t r;
    logic [2:0]  p;
    r = '0;
    case (mode)
      sfr_pkg::MODE_SPI: begin
        if (!spi_sel) begin
          r.data = b;
        end else begin
          r.data = sfr_pkg::ERASED;
          case (spi_phase)
            SPI_IDLE: begin
              if (b == sfr_pkg::OP_READ) begin
                spi_phase = SPI_ADDR;
                spi_ptr   = '0;
                spi_cnt   = '0;
              end else begin
                spi_phase = SPI_IGNORE;
              end
            end
            SPI_ADDR: begin
              spi_ptr = {spi_ptr[23:0], b};
              spi_cnt = spi_cnt + 2'd1;
              if (spi_cnt == sfr_pkg::ADDR_LAST) spi_phase = SPI_DATA;
            end
            SPI_DATA: begin
              r.data  = mem_byte(spi_ptr);
              spi_ptr = spi_ptr + 32'd1;
            end
            default: ;
          endcase
        end
      end
      sfr_pkg::MODE_SEL: begin
        spi_sel = sel;
        if (!sel) begin
          spi_phase = SPI_IDLE;
          spi_ptr   = '0;
          spi_cnt   = '0;
        end
      end
      sfr_pkg::MODE_FRAME: begin
        if (fs) begin
          frm_op  = b;
          frm_pos = '0;
        end else begin
          p       = (frm_pos < sfr_pkg::POS_MAX) ? frm_pos + 3'd1 : sfr_pkg::POS_MAX;
          frm_pos = p;
          if (p <= sfr_pkg::POS_ADDR2) begin
            frm_ptr = (p == sfr_pkg::POS_ADDR0) ? {24'b0, b} : {frm_ptr[23:0], b};
            if (frm_op == sfr_pkg::OP_RDID)
              r.data = (p == sfr_pkg::POS_ADDR0) ? sfr_pkg::ID_MFR
                     : (p == sfr_pkg::POS_ADDR1) ? sfr_pkg::ID_TYPE : sfr_pkg::ID_CAP;
          end else if (frm_op == sfr_pkg::OP_READ ||
                       ((frm_op == sfr_pkg::OP_FAST || frm_op == sfr_pkg::OP_QOUT ||
                         frm_op == sfr_pkg::OP_QIO) && p != sfr_pkg::POS_DUMMY)) begin
            r.data  = mem_byte(frm_ptr);
            frm_ptr = frm_ptr + 32'd1;
          end
        end
      end
      default: begin
        if (la < MEM_BYTES) flash_mem[la] = b;
        else r.rej = 1'b1;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    flash_resp_t want;
    if (!rst_n) begin
      for (int i = 0; i < MEM_BYTES; i++) flash_mem[i] = sfr_pkg::ERASED;
      spi_sel   = 1'b0;
      spi_phase = SPI_IDLE;
      spi_ptr   = '0;
      spi_cnt   = '0;
      frm_op    = '0;
      frm_pos   = '0;
      frm_ptr   = '0;
      owed_resp_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_resp_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("[%0t] unexpected output word: data %02h reject %0b",
                     $time, out_data_out, out_load_rejected);
          mismatch_count++;
        end else begin
          want = owed_resp_q.pop_front();
          if (out_data_out !== want.data || out_load_rejected !== want.rej) begin
            if (mismatch_count < 10)
              $display("[%0t] mismatch: data exp %02h got %02h, reject exp %0b got %0b",
                       $time, want.data, out_data_out, want.rej, out_load_rejected);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        owed_resp_q.push_back(flash_response(in_mode, in_data_in, in_select,
                                             in_frame_start, in_load_addr));
    end
    words_owed = owed_resp_q.size();
  end

endmodule

// ===== bench/spi_nor_flash_read_responder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_nor_flash_read_responder_tb
// Drives directed and random traffic into the flash read responder: memory
// loads in and out of range, SPI read commands with chip select, frame reads
// (ID, status, normal, fast and quad), stray and broken sequences, with
// random idling on both channels. The checker predicts and compares; this
// module gives the verdict.
// ----------------------------------------------------------------------------
module spi_nor_flash_read_responder_tb;

  localparam int ITEM_COUNT     = 600;
  localparam int CALM_ITEMS     = 80;
  localparam int WATCHDOG_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [7:0]  in_data_in;
  logic        in_select;
  logic        in_frame_start;
  logic [23:0] in_load_addr;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_data_out;
  logic        out_load_rejected;

  int          words_owed;
  int          mismatch_count;
  int          n_sent;
  int          idle_cycles;
  int          stall_left;
  logic        calm;
  bit          tx_gappy;
  bit          rx_bursty = 1'b1;

  logic [7:0] frame_ops [6] = '{sfr_pkg::OP_RDID, sfr_pkg::OP_RDSR, sfr_pkg::OP_READ,
                                sfr_pkg::OP_FAST, sfr_pkg::OP_QOUT, sfr_pkg::OP_QIO};

  spi_nor_flash_read_responder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_data_in        (in_data_in),
    .in_select         (in_select),
    .in_frame_start    (in_frame_start),
    .in_load_addr      (in_load_addr),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data_out      (out_data_out),
    .out_load_rejected (out_load_rejected)
  );

  sfr_read_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_data_in        (in_data_in),
    .in_select         (in_select),
    .in_frame_start    (in_frame_start),
    .in_load_addr      (in_load_addr),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data_out      (out_data_out),
    .out_load_rejected (out_load_rejected),
    .words_owed        (words_owed),
    .mismatch_count    (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) rx_bursty <= ~rx_bursty;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (rx_bursty && $urandom_range(0, 5) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic [1:0] mode, input logic [7:0] data, input logic sel,
                           input logic fs, input logic [23:0] addr);
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_data_in     <= data;
    in_select      <= sel;
    in_frame_start <= fs;
    in_load_addr   <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    if (!calm && tx_gappy && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic spi_xfer(input logic [7:0] b);
    send_word(sfr_pkg::MODE_SPI, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              24'($urandom()));
  endtask

  task automatic chip_select(input logic lvl);
    send_word(sfr_pkg::MODE_SEL, 8'($urandom_range(0, 255)), lvl,
              1'($urandom_range(0, 1)), 24'($urandom()));
  endtask

  task automatic frame_word(input logic [7:0] b, input logic fs);
    send_word(sfr_pkg::MODE_FRAME, b, 1'($urandom_range(0, 1)), fs, 24'($urandom()));
  endtask

  task automatic load_byte(input logic [23:0] addr, input logic [7:0] b);
    send_word(sfr_pkg::MODE_LOAD, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              addr);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_owed != 0);
    @(posedge clk);
  endtask

  // mostly low memory and the top edge so reads hit loaded data and cross the end
  function automatic logic [23:0] pick_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 24'($urandom_range(0, 63));
    if (r < 8) return 24'(sfr_pkg::MEM_BYTES_DEF - 32 + $urandom_range(0, 31));
    if (r == 8) return 24'(sfr_pkg::MEM_BYTES_DEF + $urandom_range(0, 15));
    return 24'($urandom());
  endfunction

  initial begin
    logic [23:0] a;
    logic [7:0]  op;
    int          kind;
    int          n;
    bit          paused;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_mode        <= sfr_pkg::MODE_SPI;
    in_data_in     <= '0;
    in_select      <= 1'b0;
    in_frame_start <= 1'b0;
    in_load_addr   <= '0;
    out_stall      <= 1'b0;
    calm           <= 1'b0;
    idle_cycles    <= 0;
    n_sent   = 0;
    paused   = 0;
    tx_gappy = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    frame_word(8'h12, 1'b0);
    load_byte(24'h000000, 8'h00);
    load_byte(24'h00FFFF, 8'hA5);
    load_byte(24'h010000, 8'h5A);
    load_byte(24'hFFFFFF, 8'hFF);
    spi_xfer(8'hFF);
    chip_select(1'b1);
    chip_select(1'b1);
    spi_xfer(sfr_pkg::OP_READ);
    spi_xfer(8'h00);
    spi_xfer(8'hFF);
    spi_xfer(8'hFF);
    spi_xfer(8'h00);
    spi_xfer(8'h00);
    chip_select(1'b0);
    frame_word(sfr_pkg::OP_RDID, 1'b1);
    repeat (4) frame_word(8'hFF, 1'b0);
    frame_word(sfr_pkg::OP_RDSR, 1'b1);
    frame_word(8'h00, 1'b0);
    frame_word(sfr_pkg::OP_FAST, 1'b1);
    repeat (5) frame_word(8'h00, 1'b0);

    // random
    while (n_sent < ITEM_COUNT) begin
      if (n_sent >= ITEM_COUNT - CALM_ITEMS) calm <= 1'b1;
      if (!paused && n_sent >= ITEM_COUNT / 2) begin
        drain();
        paused = 1;
      end
      tx_gappy = ($urandom_range(0, 2) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        repeat ($urandom_range(1, 6)) load_byte(pick_addr(), 8'($urandom_range(0, 255)));
      end else if (kind < 50) begin
        if ($urandom_range(0, 3) == 0) spi_xfer(8'($urandom_range(0, 255)));
        chip_select(1'b1);
        op = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : sfr_pkg::OP_READ;
        spi_xfer(op);
        a = pick_addr();
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : 3;
        for (int i = 0; i < n; i++) spi_xfer(a[23 - 8 * i -: 8]);
        repeat ($urandom_range(1, 6)) spi_xfer(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) != 0) chip_select(1'b0);
      end else if (kind < 80) begin
        op = ($urandom_range(0, 6) == 6) ? 8'($urandom_range(0, 255))
                                         : frame_ops[$urandom_range(0, 5)];
        frame_word(op, 1'b1);
        a = pick_addr();
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : 3;
        for (int i = 0; i < n; i++) frame_word(a[23 - 8 * i -: 8], 1'b0);
        repeat ($urandom_range(0, 6)) frame_word(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 24'($urandom()));
      end
    end

    drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && words_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
